[design/palette_pixel_expander_macros.svh]
// assertion macros shared by the expander
`ifndef PALETTE_PIXEL_EXPANDER_MACROS_SVH
`define PALETTE_PIXEL_EXPANDER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PPE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ppe_pkg.sv]
// ----------------------------------------------------------------------------
// ppe_pkg
// Types, constants and helpers shared by the palette pixel expander.
// ----------------------------------------------------------------------------
package ppe_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int CMD_DEPTH_DEF     = 4;
	localparam int OUT_DEPTH_DEF     = 4;

	// configuration register codes (register index = paddr[2])
	localparam logic REG_PIXEL_MODE    = 1'b0;
	localparam logic REG_CHANNEL_SHIFT = 1'b1;

	localparam logic [1:0] MODE_PAL4   = 2'd0;
	localparam logic [1:0] MODE_PAL8   = 2'd1;
	localparam logic [1:0] MODE_DIRECT = 2'd2;
	localparam logic [1:0] MODE_RGB24  = 2'd3;

	localparam logic OP_PAL_WRITE = 1'b0;
	localparam logic OP_PIXEL     = 1'b1;

	localparam logic [1:0] MODE_RESET  = MODE_PAL4;
	localparam logic [2:0] SHIFT_RESET = 3'd3;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  palette_index;
		logic [14:0] palette_color;
		logic [15:0] pixel_data;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last_of_run;
	} pix_out_t;

	typedef enum logic [2:0] {
		CMD_WRITE,
		CMD_PAL_TWO,
		CMD_PAL_ONE,
		CMD_DIRECT,
		CMD_RGB
	} cmd_kind_t;

	// data layout by kind:
	//   write:   [7:0] index, [22:8] colour
	//   pal_two: [7:0] low nibble index, [15:8] high nibble index
	//   pal_one: [7:0] index
	//   direct:  [14:0] colour
	//   rgb:     [7:0] red, [15:8] green, [23:16] blue
	typedef struct packed {
		cmd_kind_t   kind;
		logic [23:0] data;
	} cmd_t;

	// 5-bit channel shifted left and cut to a byte
	function automatic logic [7:0] widen(input logic [4:0] ch, input logic [2:0] sh);
		logic [7:0] w;
		w = {3'b000, ch};
		return w << sh;
	endfunction

endpackage

[design/ppe_queue.sv]
// ----------------------------------------------------------------------------
// ppe_queue
// Small register queue; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module ppe_queue #(
	parameter type T     = logic [7:0],
	parameter int  DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  T                             wdata,
	output logic                         full,
	input  logic                         pop,
	output T                             rdata,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	T                mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

[design/ppe_front.sv]
// ----------------------------------------------------------------------------
// ppe_front
// Takes input requests, sorts them by mode and gathers 24-bit pixels.
// ----------------------------------------------------------------------------
module ppe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ppe_pkg::pix_in_t item,
	input  logic             cmd_full,
	input  logic [1:0]       pixel_mode,
	input  logic             mode_wr,
	output logic             cmd_push,
	output ppe_pkg::cmd_t    cmd
);
	import ppe_pkg::*;

	logic [15:0] coll_q;
	logic [1:0]  cnt_q;
	logic        accept;
	logic [7:0]  pix_byte;
	logic        rgb_partial;

	assign accept      = push && !cmd_full;
	assign pix_byte    = item.pixel_data[7:0];
	assign rgb_partial = (item.opcode == OP_PIXEL) && (pixel_mode == MODE_RGB24)
		&& (cnt_q < 2'd2);
	assign cmd_push    = accept && !rgb_partial;

	always_comb begin
		cmd.kind = CMD_WRITE;
		cmd.data = {1'b0, item.palette_color, item.palette_index};
		if (item.opcode == OP_PIXEL) begin
			case (pixel_mode)
				MODE_PAL4: begin
					cmd.kind = CMD_PAL_TWO;
					cmd.data = {8'h00, 4'h0, pix_byte[7:4], 4'h0, pix_byte[3:0]};
				end
				MODE_PAL8: begin
					cmd.kind = CMD_PAL_ONE;
					cmd.data = {16'h0000, pix_byte};
				end
				MODE_DIRECT: begin
					cmd.kind = CMD_DIRECT;
					cmd.data = {9'h000, item.pixel_data[14:0]};
				end
				default: begin
					cmd.kind = CMD_RGB;
					cmd.data = {pix_byte, coll_q[15:8], coll_q[7:0]};
				end
			endcase
		end
	end

	// collects the first two bytes of a 24-bit pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coll_q <= '0;
			cnt_q  <= '0;
		end else if (mode_wr) begin
			coll_q <= '0;
			cnt_q  <= '0;
		end else if (accept && item.opcode == OP_PIXEL && pixel_mode == MODE_RGB24) begin
			if (cnt_q == 2'd0) begin
				coll_q <= {8'h00, pix_byte};
				cnt_q  <= 2'd1;
			end else if (cnt_q == 2'd1) begin
				coll_q <= {pix_byte, coll_q[7:0]};
				cnt_q  <= 2'd2;
			end else begin
				coll_q <= '0;
				cnt_q  <= 2'd0;
			end
		end
	end

endmodule

[design/ppe_back.sv]
// ----------------------------------------------------------------------------
// ppe_back
// Owns the palette, carries out queued requests and forms result pixels.
// ----------------------------------------------------------------------------
module ppe_back #(
	parameter int PALETTE_DEPTH = ppe_pkg::PALETTE_DEPTH_DEF,
	parameter int OUT_DEPTH     = ppe_pkg::OUT_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ppe_pkg::cmd_t                      cmd,
	input  logic                               cmd_empty,
	output logic                               cmd_pop,
	input  logic [2:0]                         channel_shift,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
	output logic                               out_push,
	output ppe_pkg::pix_out_t                  out_item
);
	import ppe_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int CW = $clog2(OUT_DEPTH + 1);

	logic [14:0]   pal_mem [PALETTE_DEPTH];

	logic          phase_q;
	logic          valid_s1;
	logic          rgb_s1;
	logic          direct_s1;
	logic          zero_s1;
	logic          last_s1;
	logic [23:0]   data_s1;
	logic [14:0]   rdata_s1;

	logic [7:0]    rd_idx;
	logic          rd_in_range;
	logic          wr_in_range;
	logic          credit;
	logic          issue;
	logic          is_write;
	logic          is_two;
	logic [CW:0]   pending;
	logic [14:0]   color;

	assign is_write    = (cmd.kind == CMD_WRITE);
	assign is_two      = (cmd.kind == CMD_PAL_TWO);
	assign rd_idx      = phase_q ? cmd.data[15:8] : cmd.data[7:0];
	assign rd_in_range = ({1'b0, rd_idx} < 9'(PALETTE_DEPTH));
	assign wr_in_range = ({1'b0, cmd.data[7:0]} < 9'(PALETTE_DEPTH));

	// results already queued plus the one in flight must leave room
	assign pending  = {1'b0, out_count} + {{CW{1'b0}}, valid_s1};
	assign credit   = (pending < (CW + 1)'(OUT_DEPTH));
	assign issue    = !cmd_empty && (is_write || credit);
	assign cmd_pop  = issue && (!is_two || phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue && !is_write;
			if (issue && is_two) phase_q <= !phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			data_s1   <= cmd.data;
			rgb_s1    <= 1'b0;
			direct_s1 <= 1'b0;
			zero_s1   <= !rd_in_range;
			last_s1   <= !is_two || phase_q;
			case (cmd.kind)
				CMD_RGB:    rgb_s1    <= 1'b1;
				CMD_DIRECT: direct_s1 <= 1'b1;
				default:    ;
			endcase
		end
	end

	// palette: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (issue && is_write && wr_in_range) begin
			pal_mem[cmd.data[AW-1:0]] <= cmd.data[22:8];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) rdata_s1 <= pal_mem[rd_idx[AW-1:0]];
	end

	always_comb begin
		if (direct_s1) begin
			color = data_s1[14:0];
		end else if (zero_s1) begin
			color = '0;
		end else begin
			color = rdata_s1;
		end
		out_item.last_of_run = last_s1;
		if (rgb_s1) begin
			out_item.red   = data_s1[7:0];
			out_item.green = data_s1[15:8];
			out_item.blue  = data_s1[23:16];
		end else begin
			out_item.red   = widen(color[4:0], channel_shift);
			out_item.green = widen(color[9:5], channel_shift);
			out_item.blue  = widen(color[14:10], channel_shift);
		end
	end

	assign out_push = valid_s1;

endmodule

[design/palette_pixel_expander.sv]
// path: a pixel request passes the request queue, s1 registers and result queue
// throughput: one request per cycle while the queues have room; a 4-bit
//   indexed byte holds the back end for two single-port palette reads, one per pixel
// reset: mode, shift, byte collector and all queues clear at once; palette
//   contents stay undefined until written, with no clearing pass
// ----------------------------------------------------------------------------
// palette_pixel_expander
// Expands palette-indexed, 15-bit and 24-bit pixels to blue, green and red.
// ----------------------------------------------------------------------------
`include "palette_pixel_expander_macros.svh"

module palette_pixel_expander #(
	parameter int PALETTE_DEPTH = ppe_pkg::PALETTE_DEPTH_DEF,
	parameter int CMD_DEPTH     = ppe_pkg::CMD_DEPTH_DEF,
	parameter int OUT_DEPTH     = ppe_pkg::OUT_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              push,
	output logic              full,
	input  ppe_pkg::pix_in_t  item,
	output logic              empty,
	input  logic              pop,
	output ppe_pkg::pix_out_t result
);
	import ppe_pkg::*;

	localparam int CCW = $clog2(CMD_DEPTH + 1);
	localparam int OCW = $clog2(OUT_DEPTH + 1);

	logic [1:0]     mode_q;
	logic [2:0]     shift_q;
	logic           cfg_wr;
	logic           mode_wr;

	logic           cmd_push;
	cmd_t           cmd_in;
	cmd_t           cmd_out;
	logic           cmd_full;
	logic           cmd_empty;
	logic           cmd_pop;
	logic [CCW-1:0] cmd_count;

	logic           out_push;
	pix_out_t       out_in;
	logic           out_full;
	logic [OCW-1:0] out_count;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign mode_wr = cfg_wr && (paddr[2] == REG_PIXEL_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RESET;
			shift_q <= SHIFT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_PIXEL_MODE:    mode_q  <= pwdata[1:0];
				REG_CHANNEL_SHIFT: shift_q <= pwdata[2:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PIXEL_MODE:    prdata = {30'h0, mode_q};
			REG_CHANNEL_SHIFT: prdata = {29'h0, shift_q};
			default:           prdata = '0;
		endcase
	end

	assign full = cmd_full;

	ppe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.cmd_full   (cmd_full),
		.pixel_mode (mode_q),
		.mode_wr    (mode_wr),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	ppe_queue #(
		.T     (cmd_t),
		.DEPTH (CMD_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	ppe_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.OUT_DEPTH     (OUT_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_out),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.channel_shift (shift_q),
		.out_count     (out_count),
		.out_push      (out_push),
		.out_item      (out_in)
	);

	ppe_queue #(
		.T     (pix_out_t),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_in),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty),
		.count  (out_count)
	);

	// result credit must never let a pixel hit a full queue
	`PPE_ASSERT_IMPL(a_out_no_overflow, out_push, !out_full, "result pushed into full queue")
	`PPE_ASSERT_IMPL(a_cmd_pop_valid, cmd_pop, cmd_count != '0, "request popped from empty queue")
	`PPE_ASSERT_NEXT(a_last_result_drains,
		pop && !empty && !out_push && out_count == OCW'(1), empty,
		"result queue not empty after last pop")

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the palette pixel expander with palette writes and pixel bytes in
// all four pixel modes and a range of channel shifts, with random gaps on the
// input side and random stalls on the output side. A scoreboard predicts the
// blue, green and red bytes of every pixel and checks them in order.
// ----------------------------------------------------------------------------
module testbench;
	import ppe_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int RESET_LEN   = 6;
	localparam int SETTLE_LEN  = 8;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 165;
	localparam int HOLD_LEN    = 400;
	localparam int CYCLE_LIMIT = 500000;

	localparam logic [2:0] ADDR_PIXEL_MODE    = {REG_PIXEL_MODE, 2'b00};
	localparam logic [2:0] ADDR_CHANNEL_SHIFT = {REG_CHANNEL_SHIFT, 2'b00};

	class pixel_scoreboard;
		pix_out_t    pending_pixels[$];
		logic [14:0] palette[256];
		logic [1:0]  mode;
		logic [2:0]  shift;
		logic [15:0] collector;
		int unsigned rgb_bytes;
		int unsigned n_requests;
		int unsigned n_pixels;
		int unsigned errors;

		function new();
			mode      = MODE_RESET;
			shift     = SHIFT_RESET;
			collector = '0;
			rgb_bytes = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void set_mode(logic [1:0] m);
			mode      = m;
			collector = '0;
			rgb_bytes = 0;
		endfunction

		function void set_shift(logic [2:0] s);
			shift = s;
		endfunction

		function logic [7:0] expand_channel(logic [4:0] ch);
			logic [7:0] w;
			w = {3'b000, ch};
			return w << shift;
		endfunction

		function void push_color(logic [14:0] color, logic last);
			pix_out_t px;
			px.blue        = expand_channel(color[14:10]);
			px.green       = expand_channel(color[9:5]);
			px.red         = expand_channel(color[4:0]);
			px.last_of_run = last;
			pending_pixels.push_back(px);
		endfunction

		function void note_request(pix_in_t it);
			pix_out_t   px;
			logic [7:0] b;
			b = it.pixel_data[7:0];
			n_requests++;
			if (it.opcode == OP_PAL_WRITE) begin
				palette[it.palette_index] = it.palette_color;
				return;
			end
			case (mode)
				MODE_PAL4: begin
					push_color(palette[{4'h0, b[3:0]}], 1'b0);
					push_color(palette[{4'h0, b[7:4]}], 1'b1);
				end
				MODE_PAL8: push_color(palette[b], 1'b1);
				MODE_DIRECT: push_color(it.pixel_data[14:0], 1'b1);
				default: begin
					if (rgb_bytes == 0) begin
						collector = {8'h00, b};
						rgb_bytes = 1;
					end else if (rgb_bytes == 1) begin
						collector[15:8] = b;
						rgb_bytes = 2;
					end else begin
						// first byte red, second green, third blue
						px.blue        = b;
						px.green       = collector[15:8];
						px.red         = collector[7:0];
						px.last_of_run = 1'b1;
						pending_pixels.push_back(px);
						collector = '0;
						rgb_bytes = 0;
					end
				end
			endcase
		endfunction

		task check_pixel(pix_out_t got);
			pix_out_t want;
			if (pending_pixels.size() == 0) begin
				report($sformatf("pixel %0d arrived with no request waiting", n_pixels));
				n_pixels++;
				return;
			end
			want = pending_pixels.pop_front();
			if (got.blue !== want.blue)
				report($sformatf("pixel %0d blue %h, want %h", n_pixels, got.blue, want.blue));
			if (got.green !== want.green)
				report($sformatf("pixel %0d green %h, want %h", n_pixels, got.green,
					want.green));
			if (got.red !== want.red)
				report($sformatf("pixel %0d red %h, want %h", n_pixels, got.red, want.red));
			if (got.last_of_run !== want.last_of_run)
				report($sformatf("pixel %0d last_of_run %b, want %b", n_pixels,
					got.last_of_run, want.last_of_run));
			n_pixels++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        push;
	logic        full;
	pix_in_t     item;
	logic        empty;
	logic        pop;
	pix_out_t    result;

	pixel_scoreboard sb;
	int unsigned     cycle_count;
	int unsigned     snd_idle;
	int unsigned     rcv_stall;
	int unsigned     hold_left;
	int unsigned     full_stalls;
	bit              pal_written[256];
	int              written_any[$];
	int              written_low[$];
	bit [3:0]        modes_seen;
	bit [7:0]        shifts_seen;

	palette_pixel_expander dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: check on every pop, then pick the next pop
	initial begin
		pop       <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				sb.check_pixel(result);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= rcv_stall);
			end
		end
	end

	task apb_write(logic [2:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering, let every pending pixel drain, then give trailing writes
	// time to land
	task settle();
		push <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_LEN) @(posedge clk);
	endtask

	task configure(logic [1:0] mode, logic [2:0] shift);
		settle();
		apb_write(ADDR_PIXEL_MODE, {30'd0, mode});
		sb.set_mode(mode);
		apb_write(ADDR_CHANNEL_SHIFT, {29'd0, shift});
		sb.set_shift(shift);
		modes_seen[mode]   = 1'b1;
		shifts_seen[shift] = 1'b1;
	endtask

	task issue(pix_in_t it);
		while ($urandom_range(0, 99) < snd_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		if (it.opcode == OP_PAL_WRITE && !pal_written[it.palette_index]) begin
			pal_written[it.palette_index] = 1'b1;
			written_any.push_back(it.palette_index);
			if (it.palette_index < 16)
				written_low.push_back(it.palette_index);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) begin
			full_stalls++;
			@(posedge clk);
		end
		sb.note_request(it);
	endtask

	task issue_fields(logic op, logic [7:0] idx, logic [14:0] color, logic [15:0] data);
		pix_in_t it;
		it.opcode        = op;
		it.palette_index = idx;
		it.palette_color = color;
		it.pixel_data    = data;
		issue(it);
	endtask

	function automatic pix_in_t random_request(logic [1:0] mode);
		pix_in_t it;
		int      lo;
		int      hi;
		it.opcode        = OP_PIXEL;
		it.palette_index = 8'($urandom_range(0, 255));
		it.palette_color = 15'($urandom_range(0, 32767));
		it.pixel_data    = 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 99) < 12) begin
			it.opcode = OP_PAL_WRITE;
			// keep the 4-bit range well stocked
			if ($urandom_range(0, 1))
				it.palette_index = 8'($urandom_range(0, 15));
		end else if (mode == MODE_PAL4) begin
			lo = written_low[$urandom_range(0, written_low.size() - 1)];
			hi = written_low[$urandom_range(0, written_low.size() - 1)];
			it.pixel_data[7:0] = {hi[3:0], lo[3:0]};
		end else if (mode == MODE_PAL8) begin
			lo = written_any[$urandom_range(0, written_any.size() - 1)];
			it.pixel_data[7:0] = lo[7:0];
		end
		return it;
	endfunction

	initial begin
		int unsigned profile;
		logic [1:0]  mode;

		sb          = new();
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		push        <= 1'b0;
		item        <= '0;
		cycle_count = 0;
		snd_idle    = 0;
		rcv_stall   = 0;
		full_stalls = 0;
		modes_seen  = '0;
		shifts_seen = '0;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: palette extremes, then reset mode and shift in use
		issue_fields(OP_PAL_WRITE, 8'd0, 15'h7fff, 16'h0000);
		issue_fields(OP_PAL_WRITE, 8'd15, 15'h0000, 16'hffff);
		issue_fields(OP_PAL_WRITE, 8'd255, 15'h2aaa, 16'h0000);
		issue_fields(OP_PAL_WRITE, 8'd128, 15'h7c1f, 16'h8000);
		issue_fields(OP_PIXEL, 8'hff, 15'h7fff, 16'hff0f);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h00f0);

		configure(MODE_PAL8, 3'd7);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'hff00);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h00ff);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h0080);

		// direct colour, bit 15 ignored
		configure(MODE_DIRECT, 3'd0);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h7fff);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h8000);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'hffff);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h0000);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h2aaa);

		// one full 24-bit pixel, then a partial one dropped by a mode write
		configure(MODE_RGB24, 3'd3);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h0001);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h0002);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h0003);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h00aa);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'hff55);
		configure(MODE_RGB24, 3'd3);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'hffff);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'hff00);
		issue_fields(OP_PIXEL, 8'h00, 15'h0000, 16'h0080);

		for (int p = 0; p < PHASES; p++) begin
			mode = 2'(p % 4);
			configure(mode, 3'((p * 5) % 8));
			profile   = (p / 4 + p) % 4;
			snd_idle  = (profile == 1) ? 83 : (profile == 3) ? 27 : 0;
			rcv_stall = (profile == 2) ? 83 : (profile == 3) ? 27 : 0;
			// output held off while the input keeps pushing
			if (p == 0 || p == 7)
				hold_left = HOLD_LEN;
			for (int n = 0; n < PHASE_ITEMS; n++)
				issue(random_request(mode));
		end

		settle();
		$display("covered %0d requests and %0d pixels, modes %b, shifts %b",
			sb.n_requests, sb.n_pixels, modes_seen, shifts_seen);
		$display("input held back by full for %0d cycles", full_stalls);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
